// File: src/rls_pkg.sv
// shared types, constants and microcode table for the latency statistics block
package rls_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int SUM_WIDTH   = 48;
  localparam int DIV_CNT_W   = $clog2(SUM_WIDTH + 1);
  localparam int CLASS_NUM   = 5;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [SUM_WIDTH-1:0]   sum_t;
  typedef logic [31:0]            val32_t;
  typedef logic [9:0]             status_t;
  typedef logic [2:0]             cls_t;
  typedef logic [DIV_CNT_W-1:0]   div_cnt_t;
  typedef logic [3:0]             pc_t;
  typedef logic [3:0]             op_t;
  typedef logic [2:0]             cond_t;

  // status classes
  localparam cls_t CLASS_1XX = 3'd0;
  localparam cls_t CLASS_2XX = 3'd1;
  localparam cls_t CLASS_3XX = 3'd2;
  localparam cls_t CLASS_4XX = 3'd3;
  localparam cls_t CLASS_5XX = 3'd4;

  localparam status_t STATUS_200 = 10'd200;
  localparam status_t STATUS_300 = 10'd300;
  localparam status_t STATUS_400 = 10'd400;
  localparam status_t STATUS_500 = 10'd500;
  localparam status_t STATUS_600 = 10'd600;

  // word kinds
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // configuration register indexes
  localparam logic CFG_WINDOW_LOW  = 1'b0;
  localparam logic CFG_WINDOW_HIGH = 1'b1;

  localparam val32_t WINDOW_LOW_RST  = 32'd1;
  localparam val32_t WINDOW_HIGH_RST = 32'd60 * 32'd1000;

  typedef struct packed {
    logic    kind;
    status_t status_code;
    val32_t  latency_ms;
  } in_word_t;

  typedef struct packed {
    val32_t class1_count;
    val32_t class2_count;
    val32_t class3_count;
    val32_t class4_count;
    val32_t class5_count;
    val32_t total_count;
    val32_t average_ms;
    val32_t minimum_ms;
    val32_t maximum_ms;
  } out_word_t;

  // datapath operations
  localparam op_t OP_NOP      = 4'd0;
  localparam op_t OP_LOAD     = 4'd1;
  localparam op_t OP_COUNT    = 4'd2;
  localparam op_t OP_SAMPLE   = 4'd3;
  localparam op_t OP_DIV_INIT = 4'd4;
  localparam op_t OP_DIV_STEP = 4'd5;
  localparam op_t OP_DIV_END  = 4'd6;
  localparam op_t OP_EMIT     = 4'd7;
  localparam op_t OP_CLEAR    = 4'd8;

  // sequencer conditions
  localparam cond_t C_NEVER      = 3'd0;
  localparam cond_t C_ALWAYS     = 3'd1;
  localparam cond_t C_NO_INPUT   = 3'd2;
  localparam cond_t C_CLEAR_KIND = 3'd3;
  localparam cond_t C_OUT_WINDOW = 3'd4;
  localparam cond_t C_NO_SAMPLES = 3'd5;
  localparam cond_t C_DIV_MORE   = 3'd6;
  localparam cond_t C_OUT_BUSY   = 3'd7;

  // microcode addresses
  localparam pc_t UA_FETCH    = 4'd0;
  localparam pc_t UA_DISPATCH = 4'd1;
  localparam pc_t UA_COUNT    = 4'd2;
  localparam pc_t UA_SAMPLE   = 4'd3;
  localparam pc_t UA_DIV_INIT = 4'd4;
  localparam pc_t UA_DIV_STEP = 4'd5;
  localparam pc_t UA_DIV_END  = 4'd6;
  localparam pc_t UA_EMIT     = 4'd7;
  localparam pc_t UA_CLEAR    = 4'd8;
  localparam int  PROG_LEN    = 9;

  typedef struct packed {
    op_t   op;
    cond_t hold_cond;
    cond_t jump_cond;
    pc_t   target;
  } ctrl_word_t;

  typedef struct packed {
    logic clear_kind;
    logic out_window;
    logic no_samples;
    logic div_more;
  } dp_flags_t;

  function automatic ctrl_word_t ucode_rom(input pc_t pc);
    ctrl_word_t w;
    unique case (pc)
      UA_FETCH:    w = '{op: OP_LOAD,     hold_cond: C_NO_INPUT, jump_cond: C_NEVER,
                         target: UA_FETCH};
      UA_DISPATCH: w = '{op: OP_NOP,      hold_cond: C_NEVER, jump_cond: C_CLEAR_KIND,
                         target: UA_CLEAR};
      UA_COUNT:    w = '{op: OP_COUNT,    hold_cond: C_NEVER, jump_cond: C_OUT_WINDOW,
                         target: UA_EMIT};
      UA_SAMPLE:   w = '{op: OP_SAMPLE,   hold_cond: C_NEVER, jump_cond: C_NEVER,
                         target: UA_FETCH};
      UA_DIV_INIT: w = '{op: OP_DIV_INIT, hold_cond: C_NEVER, jump_cond: C_NO_SAMPLES,
                         target: UA_EMIT};
      UA_DIV_STEP: w = '{op: OP_DIV_STEP, hold_cond: C_NEVER, jump_cond: C_DIV_MORE,
                         target: UA_DIV_STEP};
      UA_DIV_END:  w = '{op: OP_DIV_END,  hold_cond: C_NEVER, jump_cond: C_NEVER,
                         target: UA_FETCH};
      UA_EMIT:     w = '{op: OP_EMIT,     hold_cond: C_OUT_BUSY, jump_cond: C_ALWAYS,
                         target: UA_FETCH};
      UA_CLEAR:    w = '{op: OP_CLEAR,    hold_cond: C_NEVER, jump_cond: C_ALWAYS,
                         target: UA_EMIT};
      default:     w = '{op: OP_NOP,      hold_cond: C_NEVER, jump_cond: C_ALWAYS,
                         target: UA_FETCH};
    endcase
    return w;
  endfunction

endpackage

// File: src/rls_seq.sv
// microcode sequencer: step counter, control table and conditional jumps
module rls_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  out_busy,
  input  rls_pkg::dp_flags_t    flags,
  output rls_pkg::ctrl_word_t   ctrl
);

  rls_pkg::pc_t pc_r, pc_nxt;
  logic         hold, jump;

  function automatic logic cond_eval(input rls_pkg::cond_t c, input logic iv,
                                     input logic ob, input rls_pkg::dp_flags_t f);
    logic r;
    unique case (c)
      rls_pkg::C_NEVER:      r = 1'b0;
      rls_pkg::C_ALWAYS:     r = 1'b1;
      rls_pkg::C_NO_INPUT:   r = !iv;
      rls_pkg::C_CLEAR_KIND: r = f.clear_kind;
      rls_pkg::C_OUT_WINDOW: r = f.out_window;
      rls_pkg::C_NO_SAMPLES: r = f.no_samples;
      rls_pkg::C_DIV_MORE:   r = f.div_more;
      rls_pkg::C_OUT_BUSY:   r = ob;
      default:               r = 1'b0;
    endcase
    return r;
  endfunction

  assign ctrl = rls_pkg::ucode_rom(pc_r);
  assign hold = cond_eval(ctrl.hold_cond, in_valid, out_busy, flags);
  assign jump = cond_eval(ctrl.jump_cond, in_valid, out_busy, flags);

  always_comb begin
    if (hold) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + rls_pkg::pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= rls_pkg::UA_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r < rls_pkg::pc_t'(rls_pkg::PROG_LEN))
    else $error("step counter left the program");

endmodule

// File: src/rls_dpath.sv
// statistics registers, window check and radix-2 divider for the average
module rls_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rls_pkg::ctrl_word_t   ctrl,
  input  logic                  in_take,
  input  rls_pkg::in_word_t     in_data,
  input  rls_pkg::val32_t       window_low,
  input  rls_pkg::val32_t       window_high,
  output rls_pkg::dp_flags_t    flags,
  output rls_pkg::out_word_t    result
);

  rls_pkg::in_word_t  item_r;
  rls_pkg::count_t    class_cnt_r [rls_pkg::CLASS_NUM];
  rls_pkg::count_t    class_cnt_nxt [rls_pkg::CLASS_NUM];
  rls_pkg::count_t    total_r, total_nxt;
  rls_pkg::count_t    samp_cnt_r, samp_cnt_nxt;
  rls_pkg::sum_t      sum_r, sum_nxt;
  rls_pkg::val32_t    min_r, min_nxt;
  rls_pkg::val32_t    max_r, max_nxt;
  rls_pkg::val32_t    mean_r, mean_nxt;
  rls_pkg::count_t    rem_r, rem_nxt;
  rls_pkg::sum_t      quo_r, quo_nxt;
  rls_pkg::div_cnt_t  div_cnt_r, div_cnt_nxt;

  rls_pkg::cls_t              cls;
  logic                       in_window;
  logic [rls_pkg::COUNT_WIDTH:0] div_part, div_diff, div_dvsr;
  logic                       div_ge;
  rls_pkg::val32_t            lat;

  assign lat = item_r.latency_ms;

  always_comb begin
    if (item_r.status_code >= rls_pkg::STATUS_200 && item_r.status_code < rls_pkg::STATUS_300) begin
      cls = rls_pkg::CLASS_2XX;
    end else if (item_r.status_code >= rls_pkg::STATUS_300 &&
                 item_r.status_code < rls_pkg::STATUS_400) begin
      cls = rls_pkg::CLASS_3XX;
    end else if (item_r.status_code >= rls_pkg::STATUS_400 &&
                 item_r.status_code < rls_pkg::STATUS_500) begin
      cls = rls_pkg::CLASS_4XX;
    end else if (item_r.status_code >= rls_pkg::STATUS_500 &&
                 item_r.status_code < rls_pkg::STATUS_600) begin
      cls = rls_pkg::CLASS_5XX;
    end else begin
      cls = rls_pkg::CLASS_1XX;
    end
  end

  assign in_window = (lat > window_low) && (lat < window_high);

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign div_part = {rem_r, quo_r[rls_pkg::SUM_WIDTH-1]};
  assign div_dvsr = {1'b0, samp_cnt_r};
  assign div_ge   = div_part >= div_dvsr;
  assign div_diff = div_part - div_dvsr;

  assign flags.clear_kind = item_r.kind == rls_pkg::KIND_CLEAR;
  assign flags.out_window = !in_window;
  assign flags.no_samples = samp_cnt_r == '0;
  assign flags.div_more   = div_cnt_r != rls_pkg::div_cnt_t'(1);

  always_comb begin
    class_cnt_nxt = class_cnt_r;
    total_nxt     = total_r;
    samp_cnt_nxt  = samp_cnt_r;
    sum_nxt       = sum_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    mean_nxt      = mean_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    div_cnt_nxt   = div_cnt_r;
    unique case (ctrl.op)
      rls_pkg::OP_COUNT: begin
        class_cnt_nxt[cls] = class_cnt_r[cls] + rls_pkg::count_t'(1);
        total_nxt          = total_r + rls_pkg::count_t'(1);
      end
      rls_pkg::OP_SAMPLE: begin
        samp_cnt_nxt = samp_cnt_r + rls_pkg::count_t'(1);
        sum_nxt      = sum_r + rls_pkg::sum_t'(lat);
        if (min_r == '0 || lat < min_r) begin
          min_nxt = lat;
        end
        if (max_r == '0 || lat > max_r) begin
          max_nxt = lat;
        end
      end
      rls_pkg::OP_DIV_INIT: begin
        if (samp_cnt_r == '0) begin
          mean_nxt = '0;
        end
        rem_nxt     = '0;
        quo_nxt     = sum_r;
        div_cnt_nxt = rls_pkg::div_cnt_t'(rls_pkg::SUM_WIDTH);
      end
      rls_pkg::OP_DIV_STEP: begin
        rem_nxt     = div_ge ? rls_pkg::count_t'(div_diff) : rls_pkg::count_t'(div_part);
        quo_nxt     = {quo_r[rls_pkg::SUM_WIDTH-2:0], div_ge};
        div_cnt_nxt = div_cnt_r - rls_pkg::div_cnt_t'(1);
      end
      rls_pkg::OP_DIV_END: begin
        // saturate a quotient that no longer fits in 32 bits
        if (quo_r > rls_pkg::sum_t'(rls_pkg::val32_t'('1))) begin
          mean_nxt = '1;
        end else begin
          mean_nxt = rls_pkg::val32_t'(quo_r);
        end
      end
      rls_pkg::OP_CLEAR: begin
        for (int i = 0; i < rls_pkg::CLASS_NUM; i++) begin
          class_cnt_nxt[i] = '0;
        end
        total_nxt    = '0;
        samp_cnt_nxt = '0;
        sum_nxt      = '0;
        min_nxt      = '0;
        max_nxt      = '0;
        mean_nxt     = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rls_pkg::CLASS_NUM; i++) begin
        class_cnt_r[i] <= '0;
      end
      total_r    <= '0;
      samp_cnt_r <= '0;
      sum_r      <= '0;
      min_r      <= '0;
      max_r      <= '0;
      mean_r     <= '0;
      div_cnt_r  <= '0;
    end else begin
      class_cnt_r <= class_cnt_nxt;
      total_r     <= total_nxt;
      samp_cnt_r  <= samp_cnt_nxt;
      sum_r       <= sum_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      mean_r      <= mean_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (in_take) begin
      item_r <= in_data;
    end
  end

  assign result.class1_count = rls_pkg::val32_t'(class_cnt_r[rls_pkg::CLASS_1XX]);
  assign result.class2_count = rls_pkg::val32_t'(class_cnt_r[rls_pkg::CLASS_2XX]);
  assign result.class3_count = rls_pkg::val32_t'(class_cnt_r[rls_pkg::CLASS_3XX]);
  assign result.class4_count = rls_pkg::val32_t'(class_cnt_r[rls_pkg::CLASS_4XX]);
  assign result.class5_count = rls_pkg::val32_t'(class_cnt_r[rls_pkg::CLASS_5XX]);
  assign result.total_count  = rls_pkg::val32_t'(total_r);
  assign result.average_ms   = mean_r;
  assign result.minimum_ms   = min_r;
  assign result.maximum_ms   = max_r;

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    min_r <= max_r)
    else $error("minimum above maximum");

  a_div_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == rls_pkg::OP_DIV_STEP) |-> (div_cnt_r != '0))
    else $error("divider step with exhausted bit counter");

endmodule

// File: src/response_latency_statistics.sv
// Response latency statistics monitor, top level.
// Each input word either records one finished request (status class and total counters,
// and, for a latency strictly inside the window, sample count, sum, minimum, maximum and a
// truncated average) or clears all statistics; every word returns one result word with all
// statistics as they stand after it. A microcoded sequencer steps a small datapath through
// each word one at a time. A clear word or an out-of-window latency goes from acceptance via
// dispatch and the clear or count step to emit; a sampled latency also passes the sample step
// and the radix-2 divider, which forms the average from the 48-bit sum one quotient bit per
// cycle. The result sits in an output register, so the next word is taken while it waits; the
// emit step holds only if a second result is due before the first is taken. The user must
// write the window registers via the cfg port only while idle; the block does not enforce it.
module response_latency_statistics (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rls_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rls_pkg::out_word_t   out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  rls_pkg::val32_t      cfg_wdata
);

  rls_pkg::val32_t     window_low_r, window_high_r;
  logic                out_valid_r, out_valid_nxt;
  rls_pkg::out_word_t  out_data_r;
  rls_pkg::ctrl_word_t ctrl;
  rls_pkg::dp_flags_t  flags;
  rls_pkg::out_word_t  result;
  logic                out_busy, emit_fire, in_take;

  assign in_ready  = ctrl.op == rls_pkg::OP_LOAD;
  assign in_take   = in_valid && in_ready;
  assign out_busy  = out_valid_r && !out_ready;
  assign emit_fire = (ctrl.op == rls_pkg::OP_EMIT) && !out_busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rls_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  rls_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .in_take     (in_take),
    .in_data     (in_data),
    .window_low  (window_low_r),
    .window_high (window_high_r),
    .flags       (flags),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_low_r  <= rls_pkg::WINDOW_LOW_RST;
      window_high_r <= rls_pkg::WINDOW_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rls_pkg::CFG_WINDOW_LOW:  window_low_r  <= cfg_wdata;
        rls_pkg::CFG_WINDOW_HIGH: window_high_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data_r <= result;
    end
  end

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> !in_ready)
    else $error("new word taken while one is in progress");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctrl.op == rls_pkg::OP_EMIT))
    else $error("result shown outside the emit step");

endmodule
